/* hw/rtl/trcs_pkg.sv */
package trcs_pkg;

  // Field widths fixed by the item formats.
  localparam int SEG_W    = 16;
  localparam int WIN_W    = 6;
  localparam int PHASE_W  = 2;
  localparam int CODE_W   = 2;
  localparam int OP_W     = 2;
  localparam int DUP_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Window saturation limit and significant bits of a segment number.
  localparam int MAX_WINDOW = 32;
  localparam int SEQ_BITS   = 16;
  localparam logic [WIN_W:0] WIN_CAP =
    (MAX_WINDOW > 63) ? 7'd63 : (WIN_W+1)'(MAX_WINDOW);
  localparam logic [SEG_W-1:0] SEQ_MASK =
    (SEQ_BITS >= SEG_W) ? '1 : SEG_W'((1 << SEQ_BITS) - 1);

  // Longest run of fresh segments sent for a single event.
  localparam int RUN_LIMIT = 32;
  localparam int COUNT_W   = $clog2(RUN_LIMIT);

  // Depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [WIN_W-1:0] INIT_THRESHOLD_RST = 6'd10;
  localparam logic [DUP_W-1:0] DUP_LIMIT_RST      = 4'd3;
  localparam logic [SEG_W-1:0] FINAL_SEGMENT_RST  = 16'd512;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_ACK_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_SEGMENT     = 2'd2;

  // Event kinds.
  localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd1;
  localparam logic [OP_W-1:0] OP_START   = 2'd2;

  // Phases.
  localparam logic [PHASE_W-1:0] PH_SLOW_START = 2'd0;
  localparam logic [PHASE_W-1:0] PH_AVOIDANCE  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RECOVERY   = 2'd2;

  // Event codes.
  localparam logic [CODE_W-1:0] EV_NORMAL  = 2'd0;
  localparam logic [CODE_W-1:0] EV_TIMEOUT = 2'd1;
  localparam logic [CODE_W-1:0] EV_FAST_RT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [SEG_W-1:0] ack_number;
  } item_t;

  typedef struct packed {
    logic [SEG_W-1:0]   segment;
    logic               send_valid;
    logic               is_resend;
    logic [WIN_W-1:0]   window;
    logic [PHASE_W-1:0] phase;
    logic [CODE_W-1:0]  event_code;
    logic               done_res;
    logic               last;
  } result_t;

  // One queued command: a run of count+1 results with consecutive segments.
  typedef struct packed {
    logic [SEG_W-1:0]   segment;
    logic [COUNT_W-1:0] count;
    logic               send_valid;
    logic               is_resend;
    logic [WIN_W-1:0]   window;
    logic [PHASE_W-1:0] phase;
    logic [CODE_W-1:0]  event_code;
    logic               done;
  } cmd_t;

  function automatic logic [WIN_W-1:0] sat_win(logic [WIN_W:0] w);
    return (w > WIN_CAP) ? WIN_CAP[WIN_W-1:0] : w[WIN_W-1:0];
  endfunction

endpackage

/* hw/rtl/trcs_cmd_fifo.sv */
module trcs_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  trcs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output trcs_pkg::cmd_t head,
  output logic           empty
);

  localparam int PTR_W = (trcs_pkg::QUEUE_DEPTH > 1) ? $clog2(trcs_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(trcs_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(trcs_pkg::QUEUE_DEPTH - 1);

  trcs_pkg::cmd_t   slots [trcs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(trcs_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/trcs_front.sv */
module trcs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [trcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [trcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  trcs_pkg::item_t                     item,
  output logic                                push,
  output trcs_pkg::cmd_t                      cmd,
  input  logic                                full
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [1:0] K_STATUS = 2'd0;
  localparam logic [1:0] K_START  = 2'd1;
  localparam logic [1:0] K_RESEND = 2'd2;
  localparam logic [1:0] K_SEND   = 2'd3;

  localparam int SW = trcs_pkg::SEG_W;
  localparam int WW = trcs_pkg::WIN_W;

  // Registers
  logic [WW-1:0]                   initial_threshold;
  logic [trcs_pkg::DUP_W-1:0]      dup_ack_limit;
  logic [SW-1:0]                   final_segment;
  logic [1:0]                      state;
  logic [trcs_pkg::OP_W-1:0]       op_q;
  logic [SW-1:0]                   ack_q;
  logic [1:0]                      kind;
  logic [trcs_pkg::CODE_W-1:0]     code_q;
  logic [SW:0]                     first_q;
  logic [trcs_pkg::PHASE_W-1:0]    phase_reg;
  logic [WW-1:0]                   cwnd_reg;
  logic [WW-1:0]                   threshold_reg;
  logic [SW-1:0]                   highest_sent;
  logic [SW-1:0]                   prev_new_ack;
  logic [SW-1:0]                   recent_ack;
  logic [trcs_pkg::DUP_W-1:0]      dup_count;
  logic [WW-1:0]                   new_ack_count;

  // Next values of the update cycle
  logic [trcs_pkg::PHASE_W-1:0]    phase_next;
  logic [WW-1:0]                   cwnd_next;
  logic [WW-1:0]                   threshold_next;
  logic [SW-1:0]                   prev_new_ack_next;
  logic [SW-1:0]                   recent_ack_next;
  logic [trcs_pkg::DUP_W-1:0]      dup_count_next;
  logic [WW-1:0]                   new_ack_count_next;
  logic [1:0]                      kind_next;
  logic [trcs_pkg::CODE_W-1:0]     code_next;
  logic [SW:0]                     first_next;

  logic [WW-1:0]                   nac_inc;
  logic [trcs_pkg::DUP_W-1:0]      dc_inc;
  logic [WW-1:0]                   half_win;
  logic [WW-1:0]                   grown_win;
  logic [SW:0]                     hs_plus1;

  // Emit cycle
  logic [SW:0]                     end_s;
  logic [SW:0]                     end_m1;
  logic [SW:0]                     lim_run;
  logic [SW:0]                     fin_ext;
  logic [SW:0]                     last_seg;
  logic                            has_run;
  logic [SW-1:0]                   hs_emit;

  assign item_ready = (state == S_IDLE);
  assign push       = (state == S_EMIT) && !full;

  // Event decode and state update
  always_comb begin
    nac_inc   = new_ack_count + 1'b1;
    dc_inc    = (dup_count != '1) ? dup_count + 1'b1 : dup_count;
    half_win  = cwnd_reg >> 1;
    grown_win = trcs_pkg::sat_win({1'b0, cwnd_reg} + 7'd1);
    hs_plus1  = {1'b0, highest_sent} + 17'd1;
    first_next = ({1'b0, ack_q} > hs_plus1) ? {1'b0, ack_q} : hs_plus1;

    phase_next         = phase_reg;
    cwnd_next          = cwnd_reg;
    threshold_next     = threshold_reg;
    prev_new_ack_next  = prev_new_ack;
    recent_ack_next    = recent_ack;
    dup_count_next     = dup_count;
    new_ack_count_next = new_ack_count;
    kind_next          = K_STATUS;
    code_next          = trcs_pkg::EV_NORMAL;

    case (op_q)
      trcs_pkg::OP_START: begin
        phase_next         = trcs_pkg::PH_SLOW_START;
        cwnd_next          = 6'd1;
        threshold_next     = initial_threshold;
        prev_new_ack_next  = '0;
        recent_ack_next    = '0;
        dup_count_next     = '0;
        new_ack_count_next = '0;
        kind_next          = K_START;
      end
      trcs_pkg::OP_TIMEOUT: begin
        threshold_next = half_win;
        cwnd_next      = 6'd1;
        dup_count_next = '0;
        phase_next     = trcs_pkg::PH_SLOW_START;
        code_next      = trcs_pkg::EV_TIMEOUT;
        kind_next      = K_RESEND;
      end
      trcs_pkg::OP_ACK: begin
        recent_ack_next = ack_q;
        if (ack_q > prev_new_ack) begin
          prev_new_ack_next = ack_q;
          dup_count_next    = '0;
          if (phase_reg == trcs_pkg::PH_RECOVERY) begin
            phase_next = trcs_pkg::PH_AVOIDANCE;
            cwnd_next  = trcs_pkg::sat_win({1'b0, threshold_reg});
          end else if (phase_reg == trcs_pkg::PH_AVOIDANCE) begin
            if (nac_inc >= cwnd_reg) begin
              cwnd_next          = grown_win;
              new_ack_count_next = '0;
            end else begin
              new_ack_count_next = nac_inc;
            end
            kind_next = K_SEND;
          end else begin
            cwnd_next = grown_win;
            kind_next = K_SEND;
            if (grown_win >= threshold_reg) begin
              phase_next = trcs_pkg::PH_AVOIDANCE;
            end
          end
        end else if (phase_reg == trcs_pkg::PH_RECOVERY) begin
          cwnd_next = grown_win;
          kind_next = K_SEND;
        end else if (dc_inc >= dup_ack_limit) begin
          phase_next     = trcs_pkg::PH_RECOVERY;
          threshold_next = half_win;
          cwnd_next      = trcs_pkg::sat_win({1'b0, half_win} + 7'd3);
          dup_count_next = '0;
          code_next      = trcs_pkg::EV_FAST_RT;
          kind_next      = K_RESEND;
        end else begin
          dup_count_next = dc_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // Run bounds and command build
  always_comb begin
    end_s    = {1'b0, ack_q} + {{(SW+1-WW){1'b0}}, cwnd_reg};
    end_m1   = end_s - 17'd1;
    lim_run  = first_q + (SW+1)'(trcs_pkg::RUN_LIMIT - 1);
    fin_ext  = {1'b0, final_segment};
    has_run  = (first_q < end_s) && (first_q <= fin_ext);
    last_seg = end_m1;
    if (fin_ext < last_seg) begin
      last_seg = fin_ext;
    end
    if (lim_run < last_seg) begin
      last_seg = lim_run;
    end

    hs_emit        = highest_sent;
    cmd.segment    = '0;
    cmd.count      = '0;
    cmd.send_valid = 1'b0;
    cmd.is_resend  = 1'b0;
    cmd.window     = cwnd_reg;
    cmd.phase      = phase_reg;
    cmd.event_code = code_q;

    case (kind)
      K_START: begin
        cmd.send_valid = 1'b1;
      end
      K_RESEND: begin
        if (recent_ack <= final_segment) begin
          cmd.segment    = recent_ack;
          cmd.send_valid = 1'b1;
          cmd.is_resend  = 1'b1;
        end
      end
      K_SEND: begin
        if (has_run) begin
          cmd.segment    = first_q[SW-1:0];
          cmd.count      = trcs_pkg::COUNT_W'(last_seg - first_q);
          cmd.send_valid = 1'b1;
          hs_emit        = last_seg[SW-1:0] & trcs_pkg::SEQ_MASK;
        end
      end
      default: begin
      end
    endcase
    cmd.done = (hs_emit >= final_segment);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_threshold <= trcs_pkg::INIT_THRESHOLD_RST;
      dup_ack_limit     <= trcs_pkg::DUP_LIMIT_RST;
      final_segment     <= trcs_pkg::FINAL_SEGMENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        trcs_pkg::CFG_INITIAL_THRESHOLD: initial_threshold <= cfg_data[WW-1:0];
        trcs_pkg::CFG_DUP_ACK_LIMIT:     dup_ack_limit <= cfg_data[trcs_pkg::DUP_W-1:0];
        trcs_pkg::CFG_FINAL_SEGMENT:     final_segment <= cfg_data[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      op_q  <= item.operation;
      ack_q <= item.ack_number & trcs_pkg::SEQ_MASK;
    end
    if (state == S_UPD) begin
      kind    <= kind_next;
      code_q  <= code_next;
      first_q <= first_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase_reg     <= trcs_pkg::PH_SLOW_START;
      cwnd_reg      <= 6'd1;
      threshold_reg <= trcs_pkg::INIT_THRESHOLD_RST;
      highest_sent  <= '0;
      prev_new_ack  <= '0;
      recent_ack    <= '0;
      dup_count     <= '0;
      new_ack_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          phase_reg     <= phase_next;
          cwnd_reg      <= cwnd_next;
          threshold_reg <= threshold_next;
          prev_new_ack  <= prev_new_ack_next;
          recent_ack    <= recent_ack_next;
          dup_count     <= dup_count_next;
          new_ack_count <= new_ack_count_next;
          if (op_q == trcs_pkg::OP_START) begin
            highest_sent <= '0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!full) begin
            highest_sent <= hs_emit;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_run_is_fresh: assert property (@(posedge clk) disable iff (rst)
    push && (cmd.count != '0) |-> cmd.send_valid && !cmd.is_resend)
    else $error("multi-result command that is not a run of fresh segments");

  a_sent_in_range: assert property (@(posedge clk) disable iff (rst)
    push && cmd.send_valid && !cmd.is_resend |=> highest_sent <= final_segment)
    else $error("highest sent segment beyond final segment");
`endif

endmodule

/* hw/rtl/trcs_back.sv */
module trcs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  trcs_pkg::cmd_t    head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_ready,
  output trcs_pkg::result_t result
);

  logic [trcs_pkg::COUNT_W-1:0] left;
  logic                         advance;
  logic                         in_run;

  assign advance = !result_valid || result_ready;
  assign in_run  = result_valid && !result.last;
  assign pop     = advance && !in_run && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_run || !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_run) begin
        result.segment <= result.segment + 1'b1;
        result.last    <= (left == trcs_pkg::COUNT_W'(1));
        left           <= left - 1'b1;
      end else if (!empty) begin
        result.segment    <= head.segment;
        result.send_valid <= head.send_valid;
        result.is_resend  <= head.is_resend;
        result.window     <= head.window;
        result.phase      <= head.phase;
        result.event_code <= head.event_code;
        result.done_res   <= head.done;
        result.last       <= (head.count == '0);
        left              <= head.count;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_run_counts_up: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.last
      |=> result_valid && (result.segment == $past(result.segment) + 1'b1))
    else $error("run segment did not advance by one");

  a_last_matches_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> left != '0)
    else $error("run marked unfinished with no results left");
`endif

endmodule

/* hw/rtl/tcp_reno_congestion_sender_unit.sv */
// An accepted event has its state update registered in the update state and its
// command queued in the emit state; the back part then loads the first result of it.
// No new event is taken until that command is queued, which waits while the queue is
// full; results leave one per cycle while the consumer takes them, one per run segment.
// Reset (synchronous, rst high): registers to defaults, window state cleared,
// command queue and output register emptied.
module tcp_reno_congestion_sender_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [trcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  trcs_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output trcs_pkg::result_t               result
);

  // The front part takes one event transaction at a time, updates the phase, window,
  // threshold and ack counters, and reduces the event to a single command: a run of
  // consecutive segment numbers to send, a resend of one segment, or a status result.
  // The command carries the window, phase and completion flag as they stand after the
  // event, so that every result of the run reports the same values.
  logic           push;
  logic           full;
  trcs_pkg::cmd_t push_cmd;

  // The queue lets the front part work on the next event while the back part is
  // still emitting a long run or is held up by the consumer.
  logic           pop;
  logic           empty;
  trcs_pkg::cmd_t head;

  trcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (push),
    .cmd        (push_cmd),
    .full       (full)
  );

  trcs_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // The back part expands each command into result transactions, one per cycle while
  // the consumer takes them, counting the segment number up and marking the final result
  // of the run. Its output register is loaded whenever it is empty or its result is taken.
  trcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
